// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decimal rounding design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decimal rounding assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decimal rounding assertion failed");

`endif

// ===== design/dir_pkg.sv =====
// ----------------------------------------------------------------------------
// dir_pkg
// Types and constants shared by the decimal integral rounding pipeline.
// ----------------------------------------------------------------------------
package dir_pkg;

    localparam int MAX_SCALE = 28;
    localparam int SCALE_W   = 5;
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 3;
    localparam int MANT_W    = WORD_W * NUM_WORDS;
    localparam int WIDX_W    = 2;
    localparam int DIGIT_W   = 4;
    localparam int NUM_CELLS = MAX_SCALE * NUM_WORDS;

    // Exact division of a 35-bit value by five: q = (x * RECIP) >> RECIP_SHIFT.
    localparam int HALF_W      = WORD_W + DIGIT_W - 1;
    localparam int PROD_W      = 71;
    localparam int RECIP_SHIFT = 38;
    localparam logic [35:0] RECIP = 36'd54975581389;

    localparam logic [DIGIT_W-1:0] HALF_DIGIT = 4'd5;

    typedef enum logic [1:0] {
        OP_TRUNC  = 2'd0,
        OP_FLOOR  = 2'd1,
        OP_ROUND  = 2'd2,
        OP_NEGATE = 2'd3
    } op_t;

    typedef struct packed {
        op_t         opcode;
        logic [63:0] mant_low;
        logic [31:0] mant_high;
        logic [4:0]  dec_scale;
        logic        negative;
    } dir_in_t;

    typedef struct packed {
        logic [63:0] res_mant_low;
        logic [31:0] res_mant_high;
        logic [4:0]  res_scale;
        logic        res_negative;
    } dir_out_t;

    // One transaction as it travels down the cell chain.
    typedef struct packed {
        logic                          valid;
        op_t                           op;
        logic [NUM_WORDS-1:0][WORD_W-1:0] mant;
        logic [SCALE_W-1:0]            scale;
        logic                          neg;
        logic [DIGIT_W-1:0]            rem;
        logic [DIGIT_W-1:0]            top_digit;
        logic                          sticky;
    } stage_t;

endpackage

// ===== design/decimal_integral_rounding.sv =====
// ----------------------------------------------------------------------------
// decimal_integral_rounding
// Truncate, floor, round half away from zero, or negate a 96-bit decimal.
// ----------------------------------------------------------------------------
// Result path: a request passes through the 84 cell registers, then the result register.
// Throughput: one transaction per cycle through the 84-cell divide chain, unless a held result stalls it.
// Each cell divides one 32-bit word of one divide-by-ten pass.
// Reset clears every valid flag; payload registers are not reset.
// The block is ready for traffic as soon as reset is released.
// ----------------------------------------------------------------------------
module decimal_integral_rounding (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dir_pkg::dir_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dir_pkg::dir_out_t rsp
);

    // The chain is a row of identical cells. Cell k handles pass k / 3 of the
    // repeated divide by ten, working on the mantissa words from the top word
    // down, and hands the partial remainder on to its neighbor. A cell whose
    // pass index is not below the transaction's scale, or that carries a
    // negate, forwards the transaction untouched.

    dir_pkg::stage_t                   head;
    dir_pkg::stage_t                   link [dir_pkg::NUM_CELLS+1];
    logic                              en;
    logic [dir_pkg::SCALE_W-1:0]       scale_clamped;

    // Scales beyond the supported maximum saturate for every operation.
    assign scale_clamped = (req.dec_scale > dir_pkg::SCALE_W'(dir_pkg::MAX_SCALE))
                         ? dir_pkg::SCALE_W'(dir_pkg::MAX_SCALE) : req.dec_scale;

    always_comb
    begin
        head.valid     = req_valid;
        head.op        = req.opcode;
        head.mant      = {req.mant_high, req.mant_low};
        head.scale     = scale_clamped;
        head.neg       = req.negative;
        head.rem       = '0;
        head.top_digit = '0;
        head.sticky    = 1'b0;
    end

    assign link[0]   = head;
    // A request enters whenever the chain advances.
    assign req_ready = en;

    for (genvar k = 0; k < dir_pkg::NUM_CELLS; k++)
    begin : g_cell
        dir_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .pass_idx (dir_pkg::SCALE_W'(k / dir_pkg::NUM_WORDS)),
            .word_idx (dir_pkg::WIDX_W'(dir_pkg::NUM_WORDS - 1 - (k % dir_pkg::NUM_WORDS))),
            .prev     (link[k]),
            .cur      (link[k+1])
        );
    end

    // The last stage applies the rounding increment and holds the result
    // until the consumer takes it; bubbles in the chain keep filling meanwhile.
    dir_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .last      (link[dir_pkg::NUM_CELLS]),
        .en        (en),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== design/dir_cell.sv =====
// ----------------------------------------------------------------------------
// dir_cell
// One word step of a divide-by-ten pass: divides remainder:word by ten.
// ----------------------------------------------------------------------------
module dir_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [dir_pkg::SCALE_W-1:0] pass_idx,
    input  logic [dir_pkg::WIDX_W-1:0]  word_idx,
    input  dir_pkg::stage_t             prev,
    output dir_pkg::stage_t             cur
);

    dir_pkg::stage_t                       cur_reg;
    dir_pkg::stage_t                       cur_next;
    logic                                  valid_reg;
    logic                                  active;
    logic [dir_pkg::WORD_W-1:0]            word;
    logic [dir_pkg::DIGIT_W-1:0]           rem_in;
    logic [dir_pkg::WORD_W+dir_pkg::DIGIT_W-1:0] dividend;
    logic [dir_pkg::PROD_W-1:0]            prod;
    logic [dir_pkg::WORD_W-1:0]            quot;
    logic [dir_pkg::WORD_W+dir_pkg::DIGIT_W-1:0] back;
    logic [dir_pkg::WORD_W+dir_pkg::DIGIT_W-1:0] diff;
    logic [dir_pkg::DIGIT_W-1:0]           digit;

    assign active = (pass_idx < prev.scale) && (prev.op != dir_pkg::OP_NEGATE);

    always_comb
    begin
        unique case (word_idx)
            2'd0:    word = prev.mant[0];
            2'd1:    word = prev.mant[1];
            default: word = prev.mant[2];
        endcase
    end

    // The top word opens a fresh pass, so it starts from a zero remainder.
    assign rem_in   = (word_idx == dir_pkg::WIDX_W'(dir_pkg::NUM_WORDS - 1)) ? '0 : prev.rem;
    assign dividend = {rem_in, word};
    // Dividing by ten is halving followed by an exact reciprocal divide by five.
    assign prod     = dir_pkg::PROD_W'(dividend[dir_pkg::WORD_W+dir_pkg::DIGIT_W-1:1])
                    * dir_pkg::PROD_W'(dir_pkg::RECIP);
    assign quot     = prod[dir_pkg::RECIP_SHIFT +: dir_pkg::WORD_W];
    assign back     = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign diff     = dividend - back;
    assign digit    = diff[dir_pkg::DIGIT_W-1:0];

    always_comb
    begin
        cur_next = prev;
        if (active)
        begin
            unique case (word_idx)
                2'd0:    cur_next.mant[0] = quot;
                2'd1:    cur_next.mant[1] = quot;
                default: cur_next.mant[2] = quot;
            endcase
            cur_next.rem = digit;
            if (word_idx == '0)
            begin
                cur_next.top_digit = digit;
                cur_next.sticky    = prev.sticky | (digit != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= cur_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cur_reg <= cur_next;
        end
    end

    // The valid flag comes from the reset register; the payload is not reset.
    always_comb
    begin
        cur       = cur_reg;
        cur.valid = valid_reg;
    end

endmodule

// ===== design/dir_round.sv =====
// ----------------------------------------------------------------------------
// dir_round
// Final increment, sign and scale selection, and the registered result port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dir_round (
    input  logic              clk,
    input  logic              rst_n,
    input  dir_pkg::stage_t   last,
    output logic              en,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dir_pkg::dir_out_t rsp
);

    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    dir_pkg::dir_out_t             rsp_reg;
    dir_pkg::dir_out_t             rsp_next;
    logic                          inc;
    logic [dir_pkg::MANT_W-1:0]    mant_sum;
    logic                          load;

    // The chain moves whenever the result slot is free or being taken, or its tail is a bubble.
    assign en   = !rsp_valid_reg || rsp_ready || !last.valid;
    assign load = last.valid && en;

    assign inc = ((last.op == dir_pkg::OP_FLOOR) && last.neg && last.sticky)
              || ((last.op == dir_pkg::OP_ROUND) && (last.top_digit >= dir_pkg::HALF_DIGIT));
    assign mant_sum = last.mant + dir_pkg::MANT_W'(inc);

    always_comb
    begin
        rsp_next.res_mant_low  = mant_sum[63:0];
        rsp_next.res_mant_high = mant_sum[dir_pkg::MANT_W-1:64];
        if (last.op == dir_pkg::OP_NEGATE)
        begin
            rsp_next.res_scale    = last.scale;
            rsp_next.res_negative = !last.neg;
        end
        else
        begin
            rsp_next.res_scale    = '0;
            rsp_next.res_negative = last.neg;
        end
    end

    always_comb
    begin
        priority if (load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `DIR_ASSERT_IMP(a_stall_only_on_full, clk, rst_n, !en, rsp_valid_reg && !rsp_ready)
    `DIR_ASSERT_IMP(a_no_carry_out, clk, rst_n, last.valid && inc, ~last.mant != '0)
    `DIR_ASSERT_NXT(a_zero_scale, clk, rst_n, load && (last.op != dir_pkg::OP_NEGATE), rsp_reg.res_scale == '0)

endmodule
